// ===== hdl/scbpa_pkg.sv =====
// Shared types and constants for the size-class block pool allocator.
`default_nettype none

package scbpa_pkg;

  // Field widths fixed by the register map and the transaction formats.
  localparam int SIZE_W     = 13;
  localparam int COUNT_W    = 5;
  localparam int CFG_DATA_W = 13;
  localparam int REQ_W      = 16;
  localparam int OFF_W      = 18;
  localparam int OUT_CLS_W  = 2;
  localparam int OUT_IDX_W  = 4;

  localparam logic [OFF_W-1:0] OFFSET_MAX = '1;

  // Register values after reset, per class.
  localparam logic [SIZE_W-1:0]  RST_SIZE_0  = 13'd100;
  localparam logic [SIZE_W-1:0]  RST_SIZE_1  = 13'd500;
  localparam logic [SIZE_W-1:0]  RST_SIZE_2  = 13'd1000;
  localparam logic [COUNT_W-1:0] RST_COUNT_0 = 5'd10;
  localparam logic [COUNT_W-1:0] RST_COUNT_1 = 5'd5;
  localparam logic [COUNT_W-1:0] RST_COUNT_2 = 5'd5;

  // Request kinds.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_NO_CLASS  = 3'd2,
    ST_FREED     = 3'd3,
    ST_BAD_FREE  = 3'd4
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/size_class_block_pool_allocator.sv =====
// Top level of the size-class block pool allocator: sequencer, shared datapath and state.
//
// The pool is cut into NUM_CLASSES size classes laid out one after another. Each
// block has a header of HEADER_BYTES followed by its payload. Requests arrive on the
// in_ stream: in_tuser says allocate or free, in_tdata carries the requested size and
// the offset to free. Each request transaction produces exactly one result
// transaction on the out_ stream with a status in out_tuser and the payload offset,
// class and block index in out_tdata. Class sizes and counts are written on the cfg_
// channel, which is always ready; writes are meant to happen only while the block is
// idle, and the pool layout follows the new values at once.
// A request is worked on by a small sequencer around one multiplier and one
// compare/subtract unit, and in_tready is low until it finishes. An allocate for class
// c multiplies out the span of each class before c to find its base, checks for a free
// block, multiplies out its offset and posts it; one with no matching size goes straight
// to posting. A free walks the classes in order (a span multiply and a range check each);
// the class whose range holds the offset adds log2(MAX_BLOCKS) restoring division steps.
// The result sits in an output register: if the receiver stalls, the finished result
// waits there while the next request is already being worked on; only a second
// finished result waits for the register to drain. Reset (synchronous, active low)
// marks every block free and loads the default class sizes and counts.
`default_nettype none

module size_class_block_pool_allocator
  import scbpa_pkg::*;
#(
  parameter int NUM_CLASSES  = 3,
  parameter int MAX_BLOCKS   = 16,
  parameter int HEADER_BYTES = 8,
  localparam int CfgIdxW     = (2 * NUM_CLASSES > 1) ? $clog2(2 * NUM_CLASSES) : 1
) (
  input  wire                   clk,
  input  wire                   rst_n,
  // Request stream.
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire  [39:0]           in_tdata,   // request_size[15:0], free_offset[33:16], zero pad
  input  wire  [0:0]            in_tuser,   // operation[0]
  // Result stream.
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [23:0]           out_tdata,  // payload_offset[17:0], block_class[19:18],
                                            // block_index[23:20]
  output logic [2:0]            out_tuser,  // status[2:0]
  // Configuration writes.
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [CfgIdxW-1:0]    cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_data
);

  localparam int ClsW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int IdxW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int BitW    = (IdxW > 1) ? $clog2(IdxW) : 1;
  localparam int LaidW   = $clog2(MAX_BLOCKS + 1);
  localparam int StrideW = SIZE_W + 1;
  localparam int SpanW   = LaidW + StrideW;
  localparam int BaseW   = SpanW + ClsW + 1;
  localparam int DivW    = StrideW + IdxW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPAN,
    S_CHECK,
    S_DIV,
    S_POS,
    S_FIN,
    S_OUT
  } state_t;

  // Configuration registers.
  logic [SIZE_W-1:0]     size_r    [NUM_CLASSES];
  logic [SIZE_W-1:0]     size_nxt  [NUM_CLASSES];
  logic [COUNT_W-1:0]    count_r   [NUM_CLASSES];
  logic [COUNT_W-1:0]    count_nxt [NUM_CLASSES];

  // One free bit per block, set means free.
  logic [MAX_BLOCKS-1:0] free_map_r   [NUM_CLASSES];
  logic [MAX_BLOCKS-1:0] free_map_nxt [NUM_CLASSES];

  state_t                state_r, state_nxt;
  logic                  op_r, op_nxt;
  logic [OFF_W-1:0]      off_r, off_nxt;
  logic [ClsW-1:0]       match_r, match_nxt;
  logic [ClsW-1:0]       cls_r, cls_nxt;
  logic [BaseW-1:0]      base_r, base_nxt;
  logic [SpanW-1:0]      mul_r, mul_nxt;
  logic [IdxW-1:0]       idx_r, idx_nxt;
  logic [OFF_W-1:0]      rem_r, rem_nxt;
  logic [BitW-1:0]       bit_r, bit_nxt;

  status_t               res_status_r, res_status_nxt;
  logic [OFF_W-1:0]      res_off_r, res_off_nxt;
  logic [ClsW-1:0]       res_cls_r, res_cls_nxt;
  logic [IdxW-1:0]       res_idx_r, res_idx_nxt;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [OFF_W-1:0]      out_off_r, out_off_nxt;
  logic [ClsW-1:0]       out_cls_r, out_cls_nxt;
  logic [IdxW-1:0]       out_idx_r, out_idx_nxt;

  // Request fields.
  logic                  in_op;
  logic [REQ_W-1:0]      in_req;
  logic [OFF_W-1:0]      in_off;

  assign in_op  = in_tuser[0];
  assign in_req = in_tdata[REQ_W-1:0];
  assign in_off = in_tdata[REQ_W+OFF_W-1:REQ_W];

  // Lowest class whose size equals the requested size.
  logic [ClsW-1:0]       match;
  logic                  match_found;

  always_comb begin
    match       = '0;
    match_found = 1'b0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (REQ_W'(size_r[c]) == in_req) begin
        match       = ClsW'(c);
        match_found = 1'b1;
      end
    end
  end

  // Geometry of the class under work.
  logic [SIZE_W-1:0]     cur_size;
  logic [COUNT_W-1:0]    cur_count;
  logic [StrideW-1:0]    stride;
  logic [LaidW-1:0]      laid;

  assign cur_size  = size_r[cls_r];
  assign cur_count = count_r[cls_r];
  assign stride    = StrideW'(cur_size) + StrideW'(HEADER_BYTES);

  always_comb begin
    if (cur_size == '0) begin
      laid = '0;
    end else if (int'(cur_count) > MAX_BLOCKS) begin
      laid = LaidW'(MAX_BLOCKS);
    end else begin
      laid = LaidW'(cur_count);
    end
  end

  // Shared multiplier: span of a class (blocks times stride) or offset of a block.
  logic [LaidW-1:0]      mul_a;
  logic [SpanW-1:0]      mul_out;

  assign mul_a   = (state_r == S_SPAN) ? laid : LaidW'(idx_r);
  assign mul_out = SpanW'(mul_a) * SpanW'(stride);

  // Address checks for a free.
  logic [BaseW-1:0]      first;
  logic [BaseW-1:0]      off_ext;
  logic [BaseW-1:0]      rel_wide;
  logic                  in_range;
  logic [BaseW-1:0]      alloc_off;

  assign first     = base_r + BaseW'(HEADER_BYTES);
  assign off_ext   = BaseW'(off_r);
  assign rel_wide  = off_ext - first;
  assign in_range  = (laid != '0) && (off_ext >= first) && (rel_wide < BaseW'(mul_r));
  assign alloc_off = first + BaseW'(mul_r);

  // Lowest free block among those laid out in the class.
  logic [MAX_BLOCKS-1:0] cand;
  logic                  has_free;
  logic [IdxW-1:0]       low_idx;

  always_comb begin
    for (int j = 0; j < MAX_BLOCKS; j++) begin
      cand[j] = free_map_r[cls_r][j] && (j < int'(laid));
    end
    has_free = |cand;
    low_idx  = '0;
    for (int j = MAX_BLOCKS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        low_idx = IdxW'(j);
      end
    end
  end

  // One restoring division step, quotient bit bit_r.
  logic [DivW-1:0]       shifted;
  logic                  take;
  logic [OFF_W-1:0]      rem_after;
  logic [IdxW-1:0]       q_after;

  always_comb begin
    shifted   = DivW'(stride) << bit_r;
    take      = DivW'(rem_r) >= shifted;
    rem_after = rem_r;
    q_after   = idx_r;
    if (take) begin
      rem_after      = rem_r - OFF_W'(shifted);
      q_after[bit_r] = 1'b1;
    end
  end

  logic                  last_cls;
  assign last_cls = (int'(cls_r) == NUM_CLASSES - 1);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    off_nxt        = off_r;
    match_nxt      = match_r;
    cls_nxt        = cls_r;
    base_nxt       = base_r;
    mul_nxt        = mul_r;
    idx_nxt        = idx_r;
    rem_nxt        = rem_r;
    bit_nxt        = bit_r;
    res_status_nxt = res_status_r;
    res_off_nxt    = res_off_r;
    res_cls_nxt    = res_cls_r;
    res_idx_nxt    = res_idx_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_off_nxt    = out_off_r;
    out_cls_nxt    = out_cls_r;
    out_idx_nxt    = out_idx_r;
    size_nxt       = size_r;
    count_nxt      = count_r;
    free_map_nxt   = free_map_r;

    // Register writes.
    if (cfg_valid) begin
      if (int'(cfg_index) < NUM_CLASSES) begin
        size_nxt[ClsW'(cfg_index)] = cfg_data[SIZE_W-1:0];
      end else if (int'(cfg_index) < 2 * NUM_CLASSES) begin
        count_nxt[ClsW'(cfg_index - CfgIdxW'(NUM_CLASSES))] = cfg_data[COUNT_W-1:0];
      end
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_op;
          off_nxt   = in_off;
          match_nxt = match;
          cls_nxt   = '0;
          base_nxt  = '0;
          if (in_op == OP_ALLOC && !match_found) begin
            res_status_nxt = ST_NO_CLASS;
            res_off_nxt    = '0;
            res_cls_nxt    = '0;
            res_idx_nxt    = '0;
            state_nxt      = S_OUT;
          end else begin
            state_nxt = S_SPAN;
          end
        end
      end

      S_SPAN: begin
        mul_nxt   = mul_out;
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        if (op_r == OP_ALLOC) begin
          if (cls_r != match_r) begin
            // Walk past an earlier class to find the base of the matched one.
            base_nxt  = base_r + BaseW'(mul_r);
            cls_nxt   = ClsW'(cls_r + 1'b1);
            state_nxt = S_SPAN;
          end else if (!has_free) begin
            res_status_nxt = ST_EXHAUSTED;
            res_off_nxt    = '0;
            res_cls_nxt    = cls_r;
            res_idx_nxt    = '0;
            state_nxt      = S_OUT;
          end else begin
            idx_nxt   = low_idx;
            state_nxt = S_POS;
          end
        end else begin
          if (in_range) begin
            rem_nxt   = OFF_W'(rel_wide);
            idx_nxt   = '0;
            bit_nxt   = BitW'(IdxW - 1);
            state_nxt = S_DIV;
          end else if (last_cls) begin
            res_status_nxt = ST_BAD_FREE;
            res_off_nxt    = '0;
            res_cls_nxt    = '0;
            res_idx_nxt    = '0;
            state_nxt      = S_OUT;
          end else begin
            base_nxt  = base_r + BaseW'(mul_r);
            cls_nxt   = ClsW'(cls_r + 1'b1);
            state_nxt = S_SPAN;
          end
        end
      end

      S_DIV: begin
        rem_nxt = rem_after;
        idx_nxt = q_after;
        if (bit_r == '0) begin
          if (rem_after == '0) begin
            free_map_nxt[cls_r][q_after] = 1'b1;
            res_status_nxt = ST_FREED;
            res_off_nxt    = off_r;
            res_cls_nxt    = cls_r;
            res_idx_nxt    = q_after;
            state_nxt      = S_OUT;
          end else if (last_cls) begin
            // Not on a block boundary in any class.
            res_status_nxt = ST_BAD_FREE;
            res_off_nxt    = '0;
            res_cls_nxt    = '0;
            res_idx_nxt    = '0;
            state_nxt      = S_OUT;
          end else begin
            base_nxt  = base_r + BaseW'(mul_r);
            cls_nxt   = ClsW'(cls_r + 1'b1);
            state_nxt = S_SPAN;
          end
        end else begin
          bit_nxt = BitW'(bit_r - 1'b1);
        end
      end

      S_POS: begin
        mul_nxt   = mul_out;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        // A block whose payload offset does not fit the offset field does not
        // exist, and neither do the ones after it.
        if (alloc_off > BaseW'(OFFSET_MAX)) begin
          res_status_nxt = ST_EXHAUSTED;
          res_off_nxt    = '0;
          res_cls_nxt    = cls_r;
          res_idx_nxt    = '0;
        end else begin
          free_map_nxt[cls_r][idx_r] = 1'b0;
          res_status_nxt = ST_ALLOCATED;
          res_off_nxt    = OFF_W'(alloc_off);
          res_cls_nxt    = cls_r;
          res_idx_nxt    = idx_r;
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_off_nxt    = res_off_r;
          out_cls_nxt    = res_cls_r;
          out_idx_nxt    = res_idx_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        free_map_r[c] <= '1;
        size_r[c]     <= (c == 0) ? RST_SIZE_0 :
                         (c == 1) ? RST_SIZE_1 :
                         (c == 2) ? RST_SIZE_2 : '0;
        count_r[c]    <= (c == 0) ? RST_COUNT_0 :
                         (c == 1) ? RST_COUNT_1 :
                         (c == 2) ? RST_COUNT_2 : '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      free_map_r  <= free_map_nxt;
      size_r      <= size_nxt;
      count_r     <= count_nxt;
    end
    op_r         <= op_nxt;
    off_r        <= off_nxt;
    match_r      <= match_nxt;
    cls_r        <= cls_nxt;
    base_r       <= base_nxt;
    mul_r        <= mul_nxt;
    idx_r        <= idx_nxt;
    rem_r        <= rem_nxt;
    bit_r        <= bit_nxt;
    res_status_r <= res_status_nxt;
    res_off_r    <= res_off_nxt;
    res_cls_r    <= res_cls_nxt;
    res_idx_r    <= res_idx_nxt;
    out_status_r <= out_status_nxt;
    out_off_r    <= out_off_nxt;
    out_cls_r    <= out_cls_nxt;
    out_idx_r    <= out_idx_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {OUT_IDX_W'(out_idx_r), OUT_CLS_W'(out_cls_r), out_off_r};

endmodule

`default_nettype wire

// ===== dv/scbpa_tb_pkg.sv =====
// Register indexes of the allocator configuration channel, shared by the testbench files.
package scbpa_tb_pkg;

  typedef enum logic [2:0] {
    REG_CLASS_SIZE_0  = 3'd0,
    REG_CLASS_SIZE_1  = 3'd1,
    REG_CLASS_SIZE_2  = 3'd2,
    REG_CLASS_COUNT_0 = 3'd3,
    REG_CLASS_COUNT_1 = 3'd4,
    REG_CLASS_COUNT_2 = 3'd5,
    REG_UNUSED_6      = 3'd6,
    REG_UNUSED_7      = 3'd7
  } reg_index_t;

endpackage

// ===== dv/scbpa_checker.sv =====
// Checker that mirrors the pool allocator state and compares every result transaction.
module scbpa_checker
  import scbpa_pkg::*;
  import scbpa_tb_pkg::*;
#(
  parameter int NUM_CLASSES  = 3,
  parameter int MAX_BLOCKS   = 16,
  parameter int HEADER_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [39:0]       in_tdata,
  input  logic [0:0]        in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [23:0]       out_tdata,
  input  logic [2:0]        out_tuser,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [12:0]       cfg_data,
  output int unsigned       outstanding,
  output int unsigned       fail_count
);

  typedef struct packed {
    status_t                status;
    logic [OFF_W-1:0]       offset;
    logic [OUT_CLS_W-1:0]   cls;
    logic [OUT_IDX_W-1:0]   idx;
  } pool_result_t;

  logic [SIZE_W-1:0]     class_size  [NUM_CLASSES];
  logic [COUNT_W-1:0]    class_count [NUM_CLASSES];
  logic [MAX_BLOCKS-1:0] free_bits   [NUM_CLASSES];
  pool_result_t          awaited_results [$];

  // A class with zero payload size takes no pool space at all.
  function automatic int unsigned blocks_laid(int c);
    if (class_size[c] == '0) return 0;
    return (class_count[c] > MAX_BLOCKS) ? MAX_BLOCKS : class_count[c];
  endfunction

  function automatic int unsigned stride(int c);
    return class_size[c] + HEADER_BYTES;
  endfunction

  function automatic int unsigned class_base(int c);
    int unsigned b;
    b = 0;
    for (int k = 0; k < c; k++) b += blocks_laid(k) * stride(k);
    return b;
  endfunction

  // Blocks whose payload offset still fits the offset field.
  function automatic int unsigned blocks_usable(int c);
    int unsigned n, first, fit;
    n = blocks_laid(c);
    first = class_base(c) + HEADER_BYTES;
    if (n == 0 || first > OFFSET_MAX) return 0;
    fit = (OFFSET_MAX - first) / stride(c) + 1;
    return (n < fit) ? n : fit;
  endfunction

  function automatic pool_result_t serve_request(logic op, logic [REQ_W-1:0] size,
                                                 logic [OFF_W-1:0] off);
    pool_result_t r;
    int unsigned  n, first, rel, i;
    r.status = ST_NO_CLASS;
    r.offset = '0;
    r.cls    = '0;
    r.idx    = '0;
    if (op == OP_ALLOC) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (class_size[c] == size) begin
          n = blocks_usable(c);
          r.status = ST_EXHAUSTED;
          r.cls    = OUT_CLS_W'(c);
          for (int b = 0; b < n; b++) begin
            if (free_bits[c][b]) begin
              free_bits[c][b] = 1'b0;
              r.status = ST_ALLOCATED;
              r.offset = OFF_W'(class_base(c) + HEADER_BYTES + b * stride(c));
              r.idx    = OUT_IDX_W'(b);
              return r;
            end
          end
          return r;
        end
      end
      return r;
    end
    r.status = ST_BAD_FREE;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      n = blocks_usable(c);
      first = class_base(c) + HEADER_BYTES;
      if (n == 0 || off < first) continue;
      rel = off - first;
      if (rel % stride(c) != 0) continue;
      i = rel / stride(c);
      if (i >= n) continue;
      free_bits[c][i] = 1'b1;
      r.status = ST_FREED;
      r.offset = off;
      r.cls    = OUT_CLS_W'(c);
      r.idx    = OUT_IDX_W'(i);
      return r;
    end
    return r;
  endfunction

  task automatic check_result();
    pool_result_t exp_r, got;
    got.status = status_t'(out_tuser);
    got.offset = out_tdata[17:0];
    got.cls    = out_tdata[19:18];
    got.idx    = out_tdata[23:20];
    if (awaited_results.size() == 0) begin
      if (fail_count < 10)
        $display("ERROR: result with nothing pending: status %0d offset %0d class %0d index %0d",
                 got.status, got.offset, got.cls, got.idx);
      fail_count++;
    end else begin
      exp_r = awaited_results.pop_front();
      if (got.status !== exp_r.status || got.offset !== exp_r.offset ||
          got.cls !== exp_r.cls || got.idx !== exp_r.idx) begin
        if (fail_count < 10)
          $display("ERROR: expected status %0d offset %0d class %0d index %0d, got %0d %0d %0d %0d",
                   exp_r.status, exp_r.offset, exp_r.cls, exp_r.idx,
                   got.status, got.offset, got.cls, got.idx);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      class_size[0]  = RST_SIZE_0;
      class_size[1]  = RST_SIZE_1;
      class_size[2]  = RST_SIZE_2;
      class_count[0] = RST_COUNT_0;
      class_count[1] = RST_COUNT_1;
      class_count[2] = RST_COUNT_2;
      for (int c = 0; c < NUM_CLASSES; c++) free_bits[c] = '1;
      awaited_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < REG_CLASS_COUNT_0)
          class_size[cfg_index] = cfg_data[SIZE_W-1:0];
        else if (cfg_index <= REG_CLASS_COUNT_2)
          class_count[cfg_index - REG_CLASS_COUNT_0] = cfg_data[COUNT_W-1:0];
      end
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready)
        awaited_results.push_back(serve_request(in_tuser[0], in_tdata[15:0], in_tdata[33:16]));
    end
    outstanding <= awaited_results.size();
  end

endmodule

// ===== dv/tb.sv =====
// Top-level testbench of the size-class block pool allocator: stimulus, idling and verdict.
module tb
  import scbpa_pkg::*;
  import scbpa_tb_pkg::*;
;

  // Generous bound on the whole run: about six times the slowest expected run.
  localparam int RUN_LIMIT = 4_800_000;

  typedef enum int {LAYOUT_RANDOM, LAYOUT_WIDEST, LAYOUT_NARROWEST} layout_kind_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [12:0] cfg_data   = '0;

  int unsigned outstanding;
  int unsigned fail_count;

  // Percentages of cycles in which the sender holds back or the receiver stalls.
  int unsigned tx_idle_pct = 19;
  int unsigned rx_idle_pct = 64;

  // The layout last written to the block; the stimulus uses it to aim frees at real
  // block boundaries and allocates at real class sizes.
  logic [SIZE_W-1:0]  cur_size  [3];
  logic [COUNT_W-1:0] cur_count [3];

  size_class_block_pool_allocator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  scbpa_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always #6 clk = ~clk;

  // The receiver decides afresh each cycle whether to stall.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Blocks of class c that occupy pool space under the current layout.
  function automatic int unsigned slots(int c);
    if (cur_size[c] == '0) return 0;
    return (cur_count[c] > 16) ? 16 : cur_count[c];
  endfunction

  // Payload offset of block i of class c under the current layout.
  function automatic logic [OFF_W-1:0] block_payload(int c, int i);
    int unsigned b;
    b = 8;
    for (int k = 0; k < c; k++) b += slots(k) * (cur_size[k] + 8);
    return OFF_W'(b + i * (cur_size[c] + 8));
  endfunction

  // Offers one request transaction, possibly after some idle cycles, and returns at the
  // edge where it is accepted. The valid is only lowered when an idle cycle follows, so
  // it never gets two assignments in one time step.
  task automatic send_request(input logic op, input logic [REQ_W-1:0] size,
                              input logic [OFF_W-1:0] off);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b0, off, size};
    do @(posedge clk); while (!in_tready);
  endtask

  // Waits until every predicted result has come back. The first edge is skipped
  // because the checker's count is registered and lags behind the last accepted request.
  task automatic wait_for_results();
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Writes all six layout registers from cur_size and cur_count, with junk in the
  // upper bits of the count writes, and optionally the two unused indexes as well.
  task automatic write_layout(input bit with_spare);
    reg_index_t idx;
    for (int r = 0; r < (with_spare ? 8 : 6); r++) begin
      idx = reg_index_t'(r);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      if (idx <= REG_CLASS_SIZE_2)
        cfg_data <= cur_size[r];
      else if (idx <= REG_CLASS_COUNT_2)
        cfg_data <= {8'($urandom), cur_count[r - REG_CLASS_COUNT_0]};
      else
        cfg_data <= 13'($urandom);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    layout_kind_t     kind;
    int               c, pick;
    logic [REQ_W-1:0] size;
    logic [OFF_W-1:0] off;

    cur_size[0]  = RST_SIZE_0;
    cur_size[1]  = RST_SIZE_1;
    cur_size[2]  = RST_SIZE_2;
    cur_count[0] = RST_COUNT_0;
    cur_count[1] = RST_COUNT_1;
    cur_count[2] = RST_COUNT_2;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests under the reset layout: one allocate per class, sizes that
    // match nothing (zero, the field maximum, a near miss), a free, a double free, bad
    // offsets (zero, the field maximum, misaligned, one block past the last), and
    // draining the second class until it reports exhaustion.
    send_request(OP_ALLOC, 16'd100, 18'($urandom));
    send_request(OP_ALLOC, 16'd500, 18'($urandom));
    send_request(OP_ALLOC, 16'd1000, 18'($urandom));
    send_request(OP_ALLOC, 16'd0, 18'($urandom));
    send_request(OP_ALLOC, 16'hFFFF, 18'($urandom));
    send_request(OP_ALLOC, 16'd101, 18'($urandom));
    send_request(OP_FREE, 16'($urandom), block_payload(0, 0));
    send_request(OP_FREE, 16'($urandom), block_payload(0, 0));
    send_request(OP_FREE, 16'($urandom), 18'd0);
    send_request(OP_FREE, 16'($urandom), OFFSET_MAX);
    send_request(OP_FREE, 16'($urandom), block_payload(0, 0) + 18'd1);
    send_request(OP_FREE, 16'($urandom), block_payload(2, 4));
    send_request(OP_FREE, 16'($urandom), block_payload(2, 5));
    repeat (5) send_request(OP_ALLOC, 16'd500, 18'($urandom));
    in_tvalid <= 1'b0;
    wait_for_results();

    // Directed layout at the edges: the largest size with a count past the block limit,
    // a duplicate size with no blocks, and a class of zero size.
    cur_size[0]  = 13'd4096;
    cur_size[1]  = 13'd4096;
    cur_size[2]  = 13'd0;
    cur_count[0] = 5'd31;
    cur_count[1] = 5'd0;
    cur_count[2] = 5'd16;
    write_layout(1'b1);
    send_request(OP_ALLOC, 16'd4096, 18'($urandom));
    send_request(OP_ALLOC, 16'd0, 18'($urandom));
    send_request(OP_FREE, 16'($urandom), block_payload(0, 15));
    send_request(OP_FREE, 16'($urandom), block_payload(0, 16));
    send_request(OP_ALLOC, 16'd1, 18'($urandom));
    in_tvalid <= 1'b0;
    wait_for_results();

    // Random part: three idling regimes, each run through three layouts. The first
    // layout of the first regime is the widest one, that of the second the narrowest.
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct <= (phase == 0) ? 19 : (phase == 1) ? 64 : 0;
      rx_idle_pct <= (phase == 0) ? 64 : (phase == 1) ? 19 : 0;
      for (int s = 0; s < 3; s++) begin
        kind = (s != 0) ? LAYOUT_RANDOM : (phase == 0) ? LAYOUT_WIDEST :
               (phase == 1) ? LAYOUT_NARROWEST : LAYOUT_RANDOM;
        for (c = 0; c < 3; c++) begin
          case (kind)
            LAYOUT_WIDEST: begin
              cur_size[c]  = (c == 1) ? 13'd4095 : 13'd4096;
              cur_count[c] = (c == 0) ? 5'd31 : 5'd16;
            end
            LAYOUT_NARROWEST: begin
              cur_size[c]  = (c == 1) ? 13'd2 : 13'd1;
              cur_count[c] = (c == 1) ? 5'd0 : 5'd1;
            end
            default: begin
              // Zero, extreme and duplicate sizes turn up often on purpose.
              pick = $urandom_range(7);
              if (pick == 0)               cur_size[c] = 13'd0;
              else if (pick == 1)          cur_size[c] = 13'd4096;
              else if (pick == 2)          cur_size[c] = 13'd1;
              else if (pick == 3 && c > 0) cur_size[c] = cur_size[c-1];
              else                         cur_size[c] = 13'($urandom_range(1, 4096));
              cur_count[c] = ($urandom_range(3) == 0) ? 5'($urandom_range(0, 31))
                                                      : 5'($urandom_range(1, 16));
            end
          endcase
        end
        write_layout(bit'($urandom_range(1)));

        // Mostly well-formed traffic: allocates at a configured size and frees aimed at
        // block boundaries (one index past the end included), with some near misses and
        // pure noise mixed in.
        repeat (178) begin
          pick = $urandom_range(99);
          c    = $urandom_range(2);
          if (pick < 45) begin
            send_request(OP_ALLOC, 16'(cur_size[c]), 18'($urandom));
          end else if (pick < 55) begin
            case ($urandom_range(2))
              0:       size = 16'(cur_size[c]) + 16'd1;
              1:       size = 16'(cur_size[c]) - 16'd1;
              default: size = 16'($urandom);
            endcase
            send_request(OP_ALLOC, size, 18'($urandom));
          end else if (pick < 90) begin
            off = block_payload(c, $urandom_range(0, slots(c)));
            if ($urandom_range(7) == 0)
              off = $urandom_range(1) ? off + 18'd1 : off - 18'd1;
            send_request(OP_FREE, 16'($urandom), off);
          end else begin
            send_request(OP_FREE, 16'($urandom), 18'($urandom));
          end
        end
        in_tvalid <= 1'b0;
        wait_for_results();
      end
    end

    // Let the block settle past its longest request before the verdict.
    repeat (30) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin
    #RUN_LIMIT;
    $display("Verification failed");
    $finish;
  end

endmodule
